// ===== hdl/mdcb_pkg.sv =====
// Shared types and character constants for the dial command builder.
package mdcb_pkg;

    localparam int MaxBurst = 7;
    localparam int CntW     = 3;

    // Character codes
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // Item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Register indexes (paddr bit 2)
    localparam logic REG_DIAL_MODE = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    localparam logic [7:0] MAX_LEN_RESET = 8'd80;

    // Per-number state
    typedef struct packed {
        logic       prefix_sent;
        logic [7:0] emitted_count;
        logic       cut_off;
    } num_state_t;

    // Bytes produced by one item, oldest in slot 0
    typedef struct packed {
        logic [MaxBurst-1:0][7:0] bytes;
        logic [MaxBurst-1:0]      marks;
        logic [CntW-1:0]          cnt;
    } burst_t;

endpackage

// ===== hdl/mdcb_cfg.sv =====
// Configuration registers behind the APB-style port.
module mdcb_cfg
    import mdcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        dial_mode,
    output logic [7:0]  max_len
);

    logic       dial_mode_reg;
    logic [7:0] max_len_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dial_mode_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_DIAL_MODE: dial_mode_reg <= pwdata[0];
                REG_MAX_LEN:   max_len_reg   <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[2])
            REG_DIAL_MODE: prdata = {31'b0, dial_mode_reg};
            REG_MAX_LEN:   prdata = {24'b0, max_len_reg};
            default:       prdata = 32'b0;
        endcase
    end

    assign dial_mode = dial_mode_reg;
    assign max_len   = max_len_reg;

endmodule

// ===== hdl/mdcb_expand.sv =====
// Expands one item into its command bytes and computes the next number state.
module mdcb_expand
    import mdcb_pkg::*;
(
    input  logic       kind,
    input  logic [7:0] ch,
    input  logic       dial_mode,
    input  logic [7:0] max_len,
    input  num_state_t cur,
    output burst_t     burst,
    output num_state_t nxt
);

    always_comb
    begin
        logic [7:0]            lim;
        logic [2:0][7:0]       body;
        logic [1:0]            bn;
        logic [3:0][7:0]       pfx;
        logic [MaxBurst-1:0][7:0] cand;
        logic [CntW-1:0]       n;
        logic                  stop;
        logic                  cut;
        logic [8:0]            sum;
        logic [7:0]            newc;
        logic [7:0]            last_cnt;
        logic                  hit;

        lim  = (max_len == 8'd0) ? 8'd1 : max_len;
        body = '0;
        bn   = 2'd0;

        // Body bytes of the item
        if (kind == KIND_END)
        begin
            body[0] = CH_SEMI;
            body[1] = CH_CR;
            bn      = 2'd2;
        end
        else if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_COMMA
                 || ch == CH_HASH || ch == CH_STAR)
        begin
            body[0] = ch;
            bn      = 2'd1;
        end
        else if (ch == CH_AT)
        begin
            body[0] = CH_COMMA;
            body[1] = CH_COMMA;
            body[2] = CH_COMMA;
            bn      = 2'd3;
        end
        else if (ch == CH_P || ch == CH_T)
        begin
            body[0] = CH_D;
            body[1] = ch;
            bn      = 2'd2;
        end

        // Prefix goes first on the first item of a number
        pfx[0] = CH_A;
        pfx[1] = CH_T;
        pfx[2] = CH_D;
        pfx[3] = dial_mode ? CH_P : CH_T;
        cand   = '0;
        if (cur.prefix_sent)
        begin
            cand[2:0] = body;
            n         = {1'b0, bn};
        end
        else
        begin
            cand[3:0] = pfx;
            cand[6:4] = body;
            n         = {1'b0, bn} + 3'd4;
        end

        // Length check per byte; stop after the cut point
        burst.bytes = cand;
        burst.marks = '0;
        burst.cnt   = '0;
        stop        = 1'b0;
        cut         = cur.cut_off;
        last_cnt    = cur.emitted_count;
        for (int k = 0; k < MaxBurst; k++)
        begin
            sum  = {1'b0, cur.emitted_count} + 9'(k + 1);
            newc = sum[8] ? 8'hff : sum[7:0];
            hit  = newc >= lim;
            if (!cur.cut_off && !stop && CntW'(k) < n)
            begin
                burst.cnt      = CntW'(k + 1);
                last_cnt       = newc;
                burst.marks[k] = hit || (kind == KIND_END && CntW'(k) == n - 3'd1);
                if (hit)
                begin
                    stop = 1'b1;
                    cut  = 1'b1;
                end
            end
        end

        // End item returns the number state to reset
        if (kind == KIND_END)
        begin
            nxt = '0;
        end
        else
        begin
            nxt.prefix_sent   = 1'b1;
            nxt.emitted_count = last_cnt;
            nxt.cut_off       = cut;
        end
    end

endmodule

// ===== hdl/mdcb_burst.sv =====
// Output buffer: holds one item's bytes and shifts them out one beat a cycle while out_ready is high.
module mdcb_burst
    import mdcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    logic [MaxBurst-1:0][7:0] bytes_reg;
    logic [MaxBurst-1:0]      marks_reg;
    logic [CntW-1:0]          cnt_reg;
    logic                     beat;

    assign out_valid = cnt_reg != '0;
    assign beat      = out_valid && out_ready;
    assign can_load  = (cnt_reg == '0) || (cnt_reg == CntW'(1) && out_ready);
    assign out_byte  = bytes_reg[0];
    assign last      = marks_reg[0];

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.cnt;
        end
        else if (beat)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
        end
    end

    // Byte slots
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= burst.bytes;
            marks_reg <= burst.marks;
        end
        else if (beat)
        begin
            bytes_reg <= {8'h00, bytes_reg[MaxBurst-1:1]};
            marks_reg <= {1'b0, marks_reg[MaxBurst-1:1]};
        end
    end

endmodule

// ===== hdl/modem_dial_command_builder.sv =====
// An item passes through the input register, then the burst buffer, before its first
// byte is valid; the burst buffer may hold it back while the previous item drains.
// Throughput: one output beat per cycle while out_ready is high; an item is taken every
// cycle while each gives at most one byte and out_ready is high, otherwise the next item
// waits until the burst buffer is shifting out the last byte (of up to 7) of the one before.
// Reset (rst_n, async low): dial_mode 0, max_len 80, number state cleared.
module modem_dial_command_builder
    import mdcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       dial_mode;
    logic [7:0] max_len;
    logic       item_valid_reg;
    logic       kind_reg;
    logic [7:0] ch_reg;
    num_state_t state_reg;
    num_state_t state_next;
    burst_t     burst;
    logic       can_load;
    logic       consume;

    mdcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .dial_mode (dial_mode),
        .max_len   (max_len)
    );

    // Input register
    assign consume  = item_valid_reg && can_load;
    assign in_ready = !item_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            ch_reg   <= ch;
        end
    end

    mdcb_expand u_expand (
        .kind      (kind_reg),
        .ch        (ch_reg),
        .dial_mode (dial_mode),
        .max_len   (max_len),
        .cur       (state_reg),
        .burst     (burst),
        .nxt       (state_next)
    );

    // Number state advances when an item moves into the burst buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    mdcb_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume),
        .burst     (burst),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // Cut implies the prefix has gone out
    a_cut_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cut_off |-> state_reg.prefix_sent)
        else $error("cut_off set without prefix");

    // A cut number has emitted at least one byte
    a_cut_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cut_off |-> state_reg.emitted_count != 8'd0)
        else $error("cut_off with zero count");

    // End item clears the number state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && kind_reg == KIND_END) |=> state_reg == '0)
        else $error("number state not cleared at end");

    // A cut-off number emits no further bytes
    a_no_bytes_after_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && state_reg.cut_off) |=> !out_valid)
        else $error("bytes emitted after cut");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the dial command builder: queued driver, output monitor and command predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mdcb_pkg::*;

    localparam int IdleLimit = 3000;
    localparam int StallCycles = 300;
    localparam int SettleCycles = 8;
    localparam int RandomItems = 430;

    // One input beat and one output beat
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } dial_item_t;

    typedef struct packed {
        logic [7:0] code;
        logic       mark;
    } cmd_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = KIND_CHAR;
    logic [7:0]  ch = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'b000;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    modem_dial_command_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Stimulus and expectation stores
    dial_item_t dial_items_q[$];
    cmd_beat_t  cmd_bytes_q[$];

    // Predictor copy of registers and per-number state
    logic       cfg_pulse = 1'b0;
    logic [7:0] cfg_max_len = MAX_LEN_RESET;
    logic       num_prefix_done = 1'b0;
    logic [7:0] num_count = 8'd0;
    logic       num_cut = 1'b0;

    int   errors = 0;
    int   idle_cycles = 0;
    int   items_queued = 0;
    int   tx_idle_pct = 8;
    int   rx_idle_pct = 8;
    int   stall_req = 0;
    int   stall_seen = 0;
    int   stall_left = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Append one command byte unless the command is already cut
    function automatic void emit_cmd_byte(logic [7:0] b, logic is_end);
        logic [7:0] lim;
        cmd_beat_t  beat;
        if (num_cut)
            return;
        lim = (cfg_max_len == 8'd0) ? 8'd1 : cfg_max_len;
        if (num_count != 8'hff)
            num_count++;
        if (num_count >= lim)
            num_cut = 1'b1;
        beat.code = b;
        beat.mark = is_end || (num_count >= lim);
        cmd_bytes_q.push_back(beat);
    endfunction

    function automatic void emit_dial_prefix();
        if (num_prefix_done)
            return;
        num_prefix_done = 1'b1;
        emit_cmd_byte(CH_A, 1'b0);
        emit_cmd_byte(CH_T, 1'b0);
        emit_cmd_byte(CH_D, 1'b0);
        emit_cmd_byte(cfg_pulse ? CH_P : CH_T, 1'b0);
    endfunction

    // Expected command bytes for one accepted item
    function automatic void predict_dial_bytes(dial_item_t it);
        emit_dial_prefix();
        if (it.kind == KIND_END) begin
            emit_cmd_byte(CH_SEMI, 1'b0);
            emit_cmd_byte(CH_CR, 1'b1);
            num_prefix_done = 1'b0;
            num_count = 8'd0;
            num_cut = 1'b0;
        end else if ((it.ch >= CH_ZERO && it.ch <= CH_NINE) || it.ch == CH_COMMA
                     || it.ch == CH_HASH || it.ch == CH_STAR) begin
            emit_cmd_byte(it.ch, 1'b0);
        end else if (it.ch == CH_AT) begin
            repeat (3) emit_cmd_byte(CH_COMMA, 1'b0);
        end else if (it.ch == CH_P || it.ch == CH_T) begin
            emit_cmd_byte(CH_D, 1'b0);
            emit_cmd_byte(it.ch, 1'b0);
        end
    endfunction

    // Input driver: next item after acceptance, random gaps between items
    always @(negedge clk) begin : drive_items
        dial_item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (dial_items_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = dial_items_q.pop_front();
                in_valid <= 1'b1;
                kind <= nxt.kind;
                ch <= nxt.ch;
            end else begin
                in_valid <= 1'b0;
                kind <= 1'($urandom);
                ch <= 8'($urandom);
            end
        end
    end

    // Output ready: random stalls plus an occasional long hold-off
    always @(negedge clk) begin
        if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= StallCycles;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: check each output beat, predict each input beat, watchdog
    always @(posedge clk) begin : watch_beats
        cmd_beat_t  want;
        dial_item_t got_item;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (cmd_bytes_q.size() == 0) begin
                    $error("unexpected beat: out_byte %h last %b", out_byte, last);
                    errors++;
                end else begin
                    want = cmd_bytes_q.pop_front();
                    if (out_byte !== want.code) begin
                        $error("out_byte: expected %h, actual %h", want.code, out_byte);
                        errors++;
                    end
                    if (last !== want.mark) begin
                        $error("last: expected %b, actual %b", want.mark, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                got_item.kind = kind;
                got_item.ch = ch;
                predict_dial_bytes(got_item);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("** modem_dial_command_builder: FAILED **");
                $finish;
            end
        end
    end

    // Register write then read-back; upper data bits carry noise
    task automatic write_reg(input logic idx, input logic [7:0] val);
        logic [31:0] want;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        if (idx == REG_DIAL_MODE)
            pwdata <= ($urandom & 32'hffff_fffe) | {31'd0, val[0]};
        else
            pwdata <= ($urandom & 32'hffff_ff00) | {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_DIAL_MODE)
            cfg_pulse = val[0];
        else
            cfg_max_len = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        want = (idx == REG_DIAL_MODE) ? {31'd0, cfg_pulse} : {24'd0, cfg_max_len};
        if (prdata !== want) begin
            $error("prdata: expected %h, actual %h", want, prdata);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_item(input logic k, input logic [7:0] c);
        dial_item_t it;
        it.kind = k;
        it.ch = c;
        dial_items_q.push_back(it);
        items_queued++;
    endtask

    // Sender pause: wait until every item is taken and every byte has come
    task automatic wait_drained();
        while (dial_items_q.size() != 0 || in_valid || cmd_bytes_q.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // One phone number: mostly dialable characters, some noise, usually ended
    task automatic queue_number();
        int n;
        int r;
        n = $urandom_range(18);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 55)
                queue_item(KIND_CHAR, CH_ZERO + 8'($urandom_range(9)));
            else if (r < 62)
                queue_item(KIND_CHAR, CH_COMMA);
            else if (r < 67)
                queue_item(KIND_CHAR, CH_HASH);
            else if (r < 72)
                queue_item(KIND_CHAR, CH_STAR);
            else if (r < 80)
                queue_item(KIND_CHAR, CH_AT);
            else if (r < 86)
                queue_item(KIND_CHAR, $urandom_range(1) ? CH_P : CH_T);
            else
                queue_item(KIND_CHAR, 8'($urandom));
        end
        // broken numbers run into the next one without an end
        if ($urandom_range(9) != 0)
            queue_item(KIND_END, 8'($urandom));
    endtask

    initial begin
        int phase;
        int phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty number, every pass-through class, dropped bytes, then end
        queue_item(KIND_END, 8'hff);
        queue_item(KIND_CHAR, CH_ZERO);
        queue_item(KIND_CHAR, CH_NINE);
        queue_item(KIND_CHAR, CH_COMMA);
        queue_item(KIND_CHAR, CH_HASH);
        queue_item(KIND_CHAR, CH_STAR);
        queue_item(KIND_CHAR, CH_AT);
        queue_item(KIND_CHAR, CH_P);
        queue_item(KIND_CHAR, CH_T);
        queue_item(KIND_CHAR, 8'h00);
        queue_item(KIND_CHAR, 8'hff);
        queue_item(KIND_CHAR, CH_A);
        queue_item(KIND_END, 8'h00);
        wait_drained();

        // Pulse mode, zero length acts as one: cut at the first byte
        write_reg(REG_DIAL_MODE, 8'd1);
        write_reg(REG_MAX_LEN, 8'd0);
        queue_item(KIND_CHAR, CH_ZERO + 8'd5);
        queue_item(KIND_CHAR, CH_ZERO + 8'd7);
        queue_item(KIND_END, 8'h00);
        wait_drained();

        // Length reached exactly at the carriage return
        write_reg(REG_MAX_LEN, 8'd7);
        queue_item(KIND_CHAR, CH_ZERO + 8'd1);
        queue_item(KIND_END, 8'h00);
        wait_drained();

        // Cut inside the digits, end emits nothing
        write_reg(REG_MAX_LEN, 8'd6);
        queue_item(KIND_CHAR, CH_ZERO + 8'd1);
        queue_item(KIND_CHAR, CH_ZERO + 8'd2);
        queue_item(KIND_CHAR, CH_ZERO + 8'd3);
        queue_item(KIND_END, 8'h00);
        wait_drained();

        // Registers changed mid-number: letter kept, lowered length cuts next byte
        write_reg(REG_DIAL_MODE, 8'd0);
        write_reg(REG_MAX_LEN, 8'd255);
        queue_item(KIND_CHAR, CH_ZERO + 8'd4);
        wait_drained();
        write_reg(REG_DIAL_MODE, 8'd1);
        write_reg(REG_MAX_LEN, 8'd3);
        queue_item(KIND_CHAR, CH_ZERO + 8'd8);
        queue_item(KIND_END, 8'h00);
        wait_drained();

        // Random phases, each with its own register setting
        phase = 0;
        while (items_queued < RandomItems + 25) begin
            write_reg(REG_DIAL_MODE, 8'($urandom_range(1)));
            case (phase % 6)
                0: write_reg(REG_MAX_LEN, 8'd255);
                1: write_reg(REG_MAX_LEN, 8'd1);
                2: write_reg(REG_MAX_LEN, MAX_LEN_RESET);
                default: write_reg(REG_MAX_LEN, 8'($urandom_range(4, 30)));
            endcase
            tx_idle_pct = (phase == 2) ? 0 : 8;
            rx_idle_pct = (phase == 2) ? 0 : 8;
            if (phase == 4)
                stall_req++;
            phase_end = items_queued + 40;
            while (items_queued < phase_end)
                queue_number();
            wait_drained();
            phase++;
        end

        if (errors == 0)
            $display("** modem_dial_command_builder: PASSED **");
        else
            $display("** modem_dial_command_builder: FAILED **");
        $finish;
    end

endmodule
